FILE: rtl/gars_pkg.sv
// Shared types and constants for the grid axis range snap core.
package gars_pkg;

    localparam int unsigned UNITS_PER_DEGREE = 1000000;
    localparam int unsigned COORD_W          = 31;
    localparam int unsigned STEP_W           = 30;
    localparam int unsigned COUNT_W          = 31;
    localparam int unsigned MAG_W            = 32;
    localparam int unsigned DIV_STAGES       = MAG_W;
    localparam int unsigned IN_DATA_W        = 128;
    localparam int unsigned OUT_DATA_W       = 96;

    localparam logic [COORD_W-1:0] PERIOD_RESET = COORD_W'(360 * UNITS_PER_DEGREE);

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REVERSED = 1'b1;

    // Per-item side information carried along the pipeline.
    typedef struct packed {
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        logic        [STEP_W-1:0]  step;
        logic                      periodic;
        logic                      reversed;
        logic                      zero_step;
        logic                      neg_lo;
        logic                      neg_hi;
    } t_ctx;

    function automatic logic [COORD_W-1:0] sat_s31(input logic signed [33:0] v);
        logic signed [33:0] max_v;
        logic signed [33:0] min_v;
        max_v = 34'sd1073741823;
        min_v = -34'sd1073741824;
        if (v > max_v) begin
            sat_s31 = max_v[COORD_W-1:0];
        end else if (v < min_v) begin
            sat_s31 = min_v[COORD_W-1:0];
        end else begin
            sat_s31 = v[COORD_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/grid_axis_range_snap_core.sv
// Top level: grid snap of one axis range, fully pipelined with bit-serial dividers.
// Order: stage A, stage B, the divider stages, stages C, D and E, output register.
// One request per cycle unless stalled; two 32-stage restoring dividers set the depth.
// The whole pipeline advances when the output register is empty or taken.
// Reset (i_rst_n low, synchronous) clears all valid bits and loads the period
// register with 360 degrees in micro-degrees.
module grid_axis_range_snap_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gars_pkg::COORD_W-1:0]      i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // range_low[30:0], range_high[61:31], step_size[91:62], anchor[122:92], zero pad
    input  logic [gars_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // periodic[0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // first_point[30:0], last_point[61:31], point_count[92:62], zero pad
    output logic [gars_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status[0]
    output logic                              m_axis_tuser
);

    localparam int unsigned N = gars_pkg::DIV_STAGES;

    logic en;
    logic [gars_pkg::COORD_W-1:0] r_period;

    // output register
    logic                              r_ov;
    logic [gars_pkg::OUT_DATA_W-1:0]   r_odata;
    logic                              r_ouser;

    assign en            = !r_ov || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= gars_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    // ---------------- stage A: offsets from the anchor ----------------
    logic                 r_a_v;
    gars_pkg::t_ctx       r_a_ctx;
    logic signed [31:0]   r_a_xl;
    logic signed [31:0]   r_a_xh;
    gars_pkg::t_ctx       n_a_ctx;
    logic signed [30:0]   in_lo, in_hi, in_anc;

    always_comb begin
        in_lo  = s_axis_tdata[30:0];
        in_hi  = s_axis_tdata[61:31];
        in_anc = s_axis_tdata[122:92];
        n_a_ctx           = '0;
        n_a_ctx.lo        = in_lo;
        n_a_ctx.hi        = in_hi;
        n_a_ctx.step      = s_axis_tdata[91:62];
        n_a_ctx.periodic  = s_axis_tuser;
        n_a_ctx.reversed  = in_lo > in_hi;
        n_a_ctx.zero_step = s_axis_tdata[91:62] == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ctx <= n_a_ctx;
            r_a_xl  <= 32'(signed'(in_lo)) - 32'(signed'(in_anc));
            r_a_xh  <= 32'(signed'(in_hi)) - 32'(signed'(in_anc));
        end
    end

    // ---------------- divider pipeline ----------------
    logic                        r_dv [0:N];
    gars_pkg::t_ctx              r_dc [0:N];
    logic [gars_pkg::STEP_W-1:0] r_rl [0:N];
    logic [gars_pkg::STEP_W-1:0] r_rh [0:N];
    logic [gars_pkg::MAG_W-1:0]  r_ql [0:N];
    logic [gars_pkg::MAG_W-1:0]  r_qh [0:N];

    gars_pkg::t_ctx n_b_ctx;

    always_comb begin
        n_b_ctx        = r_a_ctx;
        n_b_ctx.neg_lo = r_a_xl[31];
        n_b_ctx.neg_hi = r_a_xh[31];
    end

    // stage B: take magnitudes, enter divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dc[0] <= n_b_ctx;
            r_rl[0] <= '0;
            r_rh[0] <= '0;
            r_ql[0] <= r_a_xl[31] ? 32'(-r_a_xl) : 32'(r_a_xl);
            r_qh[0] <= r_a_xh[31] ? 32'(-r_a_xh) : 32'(r_a_xh);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_div
        logic [30:0] tl, th, dv;
        logic        gl, gh;

        always_comb begin
            dv = {1'b0, r_dc[k].step};
            tl = {r_rl[k], r_ql[k][31]};
            th = {r_rh[k], r_qh[k][31]};
            gl = tl >= dv;
            gh = th >= dv;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        // shift one quotient bit in per stage
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dc[k+1] <= r_dc[k];
                r_rl[k+1] <= gl ? 30'(tl - dv) : tl[29:0];
                r_rh[k+1] <= gh ? 30'(th - dv) : th[29:0];
                r_ql[k+1] <= {r_ql[k][30:0], gl};
                r_qh[k+1] <= {r_qh[k][30:0], gh};
            end
        end
    end

    // ---------------- stage C: floor quotient and remainder ----------------
    logic                        r_c_v;
    gars_pkg::t_ctx              r_c_ctx;
    logic signed [32:0]          r_c_ql, r_c_qh;
    logic [gars_pkg::STEP_W-1:0] r_c_rl, r_c_rh;
    logic signed [32:0]          n_c_ql, n_c_qh;
    logic [gars_pkg::STEP_W-1:0] n_c_rl, n_c_rh;

    always_comb begin
        if (r_dc[N].neg_lo) begin
            n_c_ql = -$signed({1'b0, r_ql[N]}) - ((r_rl[N] != '0) ? 33'sd1 : 33'sd0);
            n_c_rl = (r_rl[N] != '0) ? r_dc[N].step - r_rl[N] : '0;
        end else begin
            n_c_ql = $signed({1'b0, r_ql[N]});
            n_c_rl = r_rl[N];
        end
        if (r_dc[N].neg_hi) begin
            n_c_qh = -$signed({1'b0, r_qh[N]}) - ((r_rh[N] != '0) ? 33'sd1 : 33'sd0);
            n_c_rh = (r_rh[N] != '0) ? r_dc[N].step - r_rh[N] : '0;
        end else begin
            n_c_qh = $signed({1'b0, r_qh[N]});
            n_c_rh = r_rh[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_dv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_ctx <= r_dc[N];
            r_c_ql  <= n_c_ql;
            r_c_qh  <= n_c_qh;
            r_c_rl  <= n_c_rl;
            r_c_rh  <= n_c_rh;
        end
    end

    // ---------------- stage D: snap both ends ----------------
    logic               r_d_v;
    gars_pkg::t_ctx     r_d_ctx;
    logic signed [32:0] r_d_first, r_d_cand;
    logic signed [33:0] r_d_qlc, r_d_qh;
    logic signed [32:0] n_d_up;

    always_comb begin
        n_d_up = (r_c_rl != '0) ? $signed({3'b0, r_c_ctx.step - r_c_rl}) : 33'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_ctx   <= r_c_ctx;
            r_d_first <= 33'(r_c_ctx.lo) + n_d_up;
            r_d_cand  <= 33'(r_c_ctx.hi) - $signed({3'b0, r_c_rh});
            r_d_qlc   <= 34'(r_c_ql) + ((r_c_rl != '0) ? 34'sd1 : 34'sd0);
            r_d_qh    <= 34'(r_c_qh);
        end
    end

    // ---------------- stage E: clamp and count ----------------
    logic               r_e_v;
    gars_pkg::t_ctx     r_e_ctx;
    logic signed [32:0] r_e_first, r_e_last;
    logic signed [34:0] r_e_cnt;
    logic signed [33:0] r_e_span;
    logic               n_e_ge;
    logic signed [32:0] n_e_last;

    always_comb begin
        n_e_ge   = r_d_cand >= r_d_first;
        n_e_last = n_e_ge ? r_d_cand : r_d_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_ctx   <= r_d_ctx;
            r_e_first <= r_d_first;
            r_e_last  <= n_e_last;
            r_e_cnt   <= n_e_ge ? 35'(r_d_qh) - 35'(r_d_qlc) + 35'sd1 : 35'sd1;
            r_e_span  <= 34'(n_e_last) - 34'(r_d_first);
        end
    end

    // ---------------- output stage: wrap fix, special cases, saturate ----------------
    logic               n_wrap;
    logic signed [34:0] n_cnt;
    logic signed [33:0] n_last;
    logic [30:0]        n_first_o, n_last_o, n_cnt_o;
    logic               n_status;

    always_comb begin
        n_wrap = r_e_ctx.periodic && (r_period != '0)
                 && (r_e_span >= $signed({3'b0, r_period}));
        n_cnt  = n_wrap ? r_e_cnt - 35'sd1 : r_e_cnt;
        n_last = n_wrap ? 34'(r_e_last) - $signed({4'b0, r_e_ctx.step}) : 34'(r_e_last);
        n_status  = gars_pkg::STATUS_OK;
        n_first_o = gars_pkg::sat_s31(34'(r_e_first));
        n_last_o  = gars_pkg::sat_s31(n_last);
        n_cnt_o   = (n_cnt > 35'sd2147483647) ? 31'h7FFF_FFFF : n_cnt[30:0];
        if (r_e_ctx.reversed) begin
            n_status  = gars_pkg::STATUS_REVERSED;
            n_first_o = '0;
            n_last_o  = '0;
            n_cnt_o   = '0;
        end else if (r_e_ctx.zero_step) begin
            n_first_o = r_e_ctx.lo;
            n_last_o  = r_e_ctx.lo;
            n_cnt_o   = 31'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_odata <= {3'b0, n_cnt_o, n_last_o, n_first_o};
            r_ouser <= n_status;
        end
    end

    // ---------------- assertions ----------------
    a_rev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ouser == gars_pkg::STATUS_REVERSED) |-> (r_odata == '0))
        else $error("reversed range result carries nonzero fields");

    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ouser == gars_pkg::STATUS_OK) |-> (r_odata[92:62] != '0))
        else $error("valid range produced zero point count");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ouser == gars_pkg::STATUS_OK)
        |-> ($signed(r_odata[61:31]) >= $signed(r_odata[30:0])))
        else $error("last point below first point");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_a_v)
        else $error("accepted request did not enter the pipeline");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r_e_v) |=> r_e_v)
        else $error("stalled stage lost its request");

endmodule
